/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker in bxf_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, switched off while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALW(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bxf_pkg.sv */
// types and constants for the 3x3 rgb box filter
// no dependencies
`default_nettype none

package bxf_pkg;

   localparam int ROW_W   = 12;
   localparam int FW_W    = 11;
   localparam int CSR_W   = 12;
   localparam int SUM_W   = 12;
   localparam int WIN_N   = 6;
   localparam int CENTRE  = 4;

   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [ROW_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // divide by nine: (sum * 7282) >> 16 is exact for sums up to 2295
   localparam logic [12:0] DIV9_MUL   = 13'd7282;
   localparam int          DIV9_SHIFT = 16;
   localparam int          PROD_W     = 25;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type pix;
      logic      frame_end;
   } out_item_type;

   typedef struct packed {
      logic pixel;
      logic drain;
      logic sel_middle;
      logic zero_u;
      logic zero_m;
      logic has_out;
      logic interior;
      logic frame_end;
   } item_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/bxf_line_ram.sv */
// one line store: single write port, one registered read port
// depends on bxf_pkg
`default_nettype none

module bxf_line_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output bxf_pkg::pixel_type rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  bxf_pkg::pixel_type wr_data
);
   import bxf_pkg::*;

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bxf_ctrl.sv */
// frame registers, input and output position counters, per-item decode
// depends on bxf_pkg
`default_nettype none

module bxf_ctrl #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  logic [bxf_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                         accept,
   input  logic                         req_kind,
   output logic                         s1_load,
   output bxf_pkg::item_ctl_type        item_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0] item_addr
);
   import bxf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

   logic [FW_W-1:0]  frame_width_ff;
   logic [ROW_W-1:0] frame_height_ff;
   logic [CW-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   logic [WW-1:0]    w_eff, in_col_p1, out_col_p1;
   logic [ROW_W-1:0] h_eff;
   logic [ROW_W:0]   h_ext, out_row_p1;
   logic             drain, pixel, emit, last;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (WW'(frame_width_ff) > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(frame_width_ff);
      end
      h_eff      = (frame_height_ff == '0) ? ROW_W'(1) : frame_height_ff;
      h_ext      = {1'b0, h_eff};
      in_col_p1  = WW'(in_col_ff) + WW'(1);
      out_col_p1 = WW'(out_col_ff) + WW'(1);
      out_row_p1 = {1'b0, out_row_ff} + (ROW_W+1)'(1);

      drain = (in_row_ff >= h_eff);
      pixel = !drain && (req_kind == KIND_PIXEL);
      last  = (out_row_p1 >= h_ext) && (out_col_p1 >= w_eff);

      item_ctl.pixel      = pixel;
      item_ctl.drain      = drain;
      item_ctl.sel_middle = (out_row_p1 >= h_ext);
      item_ctl.zero_u     = (in_row_ff < ROW_W'(2));
      item_ctl.zero_m     = (in_row_ff == '0);
      item_ctl.has_out    = drain || (in_row_ff >= ROW_W'(2))
                         || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      item_ctl.interior   = (out_row_ff != '0) && (out_row_p1 < h_ext)
                         && (out_col_ff != '0) && (out_col_p1 < w_eff);
      item_ctl.frame_end  = last;

      emit      = drain || (pixel && item_ctl.has_out);
      s1_load   = accept && (drain || pixel);
      item_addr = drain ? out_col_ff : in_col_ff;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept && pixel) begin
         if (in_col_p1 >= w_eff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_p1[CW-1:0];
         end
      end
      if (accept && emit) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_p1 >= w_eff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_p1[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/bxf_datapath.sv */
// line stores with write-back forwarding, 3x3 window, channel sums, divide by nine
// depends on bxf_pkg and bxf_line_ram
`default_nettype none

module bxf_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         run,
   input  logic                         s1_load,
   input  bxf_pkg::item_ctl_type        item_ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0] item_addr,
   input  bxf_pkg::pixel_type           item_pix,
   output logic                         push,
   output bxf_pkg::out_item_type        push_item
);
   import bxf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   // stage 1
   logic         s1_valid_ff;
   item_ctl_type s1_ctl_ff;
   logic [CW-1:0] s1_addr_ff;
   pixel_type    s1_pix_ff;

   logic          fwd_valid_ff;
   logic [CW-1:0] fwd_addr_ff;
   pixel_type     fwd_up_ff, fwd_mid_ff;

   pixel_type win_ff [WIN_N];

   pixel_type ram_up_q, ram_mid_q, up_rd, mid_rd, u_pix, m_pix, pass_pix;
   logic      hit, wr;
   logic [SUM_W-1:0] sum_r, sum_g, sum_b;

   // stage 2
   logic             s2_valid_ff, s2_mean_ff, s2_end_ff;
   logic [SUM_W-1:0] s2_sum_r_ff, s2_sum_g_ff, s2_sum_b_ff;
   pixel_type        s2_pass_ff;
   logic [PROD_W-1:0] prod_r, prod_g, prod_b;

   bxf_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
      .clock   (clock),
      .rd_en   (s1_load),
      .rd_addr (item_addr),
      .rd_data (ram_up_q),
      .wr_en   (wr),
      .wr_addr (s1_addr_ff),
      .wr_data (m_pix)
   );

   bxf_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
      .clock   (clock),
      .rd_en   (s1_load),
      .rd_addr (item_addr),
      .rd_data (ram_mid_q),
      .wr_en   (wr),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff)
   );

   always_comb begin
      hit      = fwd_valid_ff && (fwd_addr_ff == s1_addr_ff);
      up_rd    = hit ? fwd_up_ff : ram_up_q;
      mid_rd   = hit ? fwd_mid_ff : ram_mid_q;
      u_pix    = s1_ctl_ff.zero_u ? '0 : up_rd;
      m_pix    = s1_ctl_ff.zero_m ? '0 : mid_rd;
      wr       = run && s1_valid_ff && s1_ctl_ff.pixel;
      if (s1_ctl_ff.drain) begin
         pass_pix = s1_ctl_ff.sel_middle ? mid_rd : up_rd;
      end else begin
         pass_pix = win_ff[CENTRE];
      end
   end

   always_comb begin
      sum_r = SUM_W'(u_pix.red) + SUM_W'(m_pix.red) + SUM_W'(s1_pix_ff.red);
      sum_g = SUM_W'(u_pix.green) + SUM_W'(m_pix.green) + SUM_W'(s1_pix_ff.green);
      sum_b = SUM_W'(u_pix.blue) + SUM_W'(m_pix.blue) + SUM_W'(s1_pix_ff.blue);
      for (int k = 0; k < WIN_N; k++) begin
         sum_r = sum_r + SUM_W'(win_ff[k].red);
         sum_g = sum_g + SUM_W'(win_ff[k].green);
         sum_b = sum_b + SUM_W'(win_ff[k].blue);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else if (run) begin
         s1_valid_ff  <= s1_load;
         fwd_valid_ff <= wr && s1_load;
         s2_valid_ff  <= s1_valid_ff && s1_ctl_ff.has_out;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ctl_ff  <= item_ctl;
         s1_addr_ff <= item_addr;
         s1_pix_ff  <= item_pix;
      end
      if (run) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_up_ff   <= m_pix;
         fwd_mid_ff  <= s1_pix_ff;
         s2_mean_ff  <= s1_ctl_ff.pixel && s1_ctl_ff.interior;
         s2_end_ff   <= s1_ctl_ff.frame_end;
         s2_sum_r_ff <= sum_r;
         s2_sum_g_ff <= sum_g;
         s2_sum_b_ff <= sum_b;
         s2_pass_ff  <= pass_pix;
      end
   end

   // window: two earlier columns of upper, middle and current rows
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_N; k++) begin
            win_ff[k] <= '0;
         end
      end else if (wr) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= u_pix;
         win_ff[4] <= m_pix;
         win_ff[5] <= s1_pix_ff;
      end
   end

   always_comb begin
      prod_r = {{(PROD_W-SUM_W){1'b0}}, s2_sum_r_ff} * {{(PROD_W-13){1'b0}}, DIV9_MUL};
      prod_g = {{(PROD_W-SUM_W){1'b0}}, s2_sum_g_ff} * {{(PROD_W-13){1'b0}}, DIV9_MUL};
      prod_b = {{(PROD_W-SUM_W){1'b0}}, s2_sum_b_ff} * {{(PROD_W-13){1'b0}}, DIV9_MUL};
      push   = run && s2_valid_ff;
      push_item.frame_end = s2_end_ff;
      if (s2_mean_ff) begin
         push_item.pix.red   = prod_r[DIV9_SHIFT +: 8];
         push_item.pix.green = prod_g[DIV9_SHIFT +: 8];
         push_item.pix.blue  = prod_b[DIV9_SHIFT +: 8];
      end else begin
         push_item.pix = s2_pass_ff;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/bxf_out_fifo.sv */
// two-entry output queue between the pipeline and the result channel
// depends on bxf_pkg
`default_nettype none

module bxf_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bxf_pkg::out_item_type push_item,
   output logic                  has_room,
   output logic                  head_valid,
   output bxf_pkg::out_item_type head_item,
   input  logic                  pop_ready
);
   import bxf_pkg::*;

   out_item_type entry_ff [2];
   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, rd_ptr_ff, pop;

   always_comb begin
      has_room   = (count_ff != 2'd2);
      head_valid = (count_ff != 2'd0);
      head_item  = entry_ff[rd_ptr_ff];
      pop        = head_valid && pop_ready;
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rgb_box_filter_3x3.sv */
// 3x3 box filter on an rgb raster stream, border pixels pass through
// results pass stage 1, stage 2 and the output queue; throughput: one item per cycle
// while the queue has room; the line stores are read for each pixel or drain item
// and written for each pixel item; the two-entry output queue holds ready low only
// while both entries wait; reset: counters, pipeline, window and queue cleared,
// frame size 640 x 480; line stores not cleared, reads of unwritten entries zeroed
`default_nettype none

module rgb_box_filter_3x3 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic                      csr_index,
   input  logic [bxf_pkg::CSR_W-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [7:0]                req_red_in,
   input  logic [7:0]                req_green_in,
   input  logic [7:0]                req_blue_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_red_out,
   output logic [7:0]                rsp_green_out,
   output logic [7:0]                rsp_blue_out,
   output logic                      rsp_frame_end
);
   import bxf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic          run, accept, s1_load, push;
   item_ctl_type  item_ctl;
   logic [CW-1:0] item_addr;
   pixel_type     item_pix;
   out_item_type  push_item, head_item;

   assign req_ready = run;
   assign accept    = req_valid && run;
   assign item_pix  = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   bxf_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .req_kind     (req_kind),
      .s1_load      (s1_load),
      .item_ctl     (item_ctl),
      .item_addr    (item_addr)
   );

   bxf_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .s1_load   (s1_load),
      .item_ctl  (item_ctl),
      .item_addr (item_addr),
      .item_pix  (item_pix),
      .push      (push),
      .push_item (push_item)
   );

   bxf_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .has_room   (run),
      .head_valid (rsp_valid),
      .head_item  (head_item),
      .pop_ready  (rsp_ready)
   );

   assign rsp_red_out   = head_item.pix.red;
   assign rsp_green_out = head_item.pix.green;
   assign rsp_blue_out  = head_item.pix.blue;
   assign rsp_frame_end = head_item.frame_end;

endmodule

`default_nettype wire

/* hw/rtl/bxf_checker.sv */
// port-level checks on the box filter and the bind that attaches them
// depends on assert_macros.svh and rgb_box_filter_3x3
`default_nettype none
`include "assert_macros.svh"

module bxf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out,
   input logic       rsp_frame_end
);

   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped while stalled")
   `ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_end), "stalled result item changed")
   `ASSERT_ALW(a_stall_backed, clock, !req_ready |-> rsp_valid, "input stalled with no result waiting")
   `ASSERT_ALW(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "queue not empty after reset")

endmodule

bind rgb_box_filter_3x3 bxf_checker u_bxf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_frame_end (rsp_frame_end)
);

`default_nettype wire
